>>> rtl/lds_pkg.sv
// shared constants, command codes and controller states of the look disk scheduler
// no dependencies

package lds_pkg;

   localparam int MAX_REQUESTS_DEF = 64;
   localparam int CYL_BITS_DEF     = 16;
   localparam int CYL_PORT_W       = 16;
   localparam int SEEK_W           = 22;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam logic DIR_RIGHT = 1'b0;
   localparam logic DIR_LEFT  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_CMP,
      ST_LD_WR,
      ST_EMPTY,
      ST_SP_RD,
      ST_SP_CMP,
      ST_EM_RD,
      ST_EM_DIF,
      ST_EM_OUT
   } state_type;

endpackage

>>> rtl/lds_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module lds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/look_disk_scheduler_core.sv
// look disk scheduler: keeps pending cylinder requests sorted and emits them in look order
// depends on lds_pkg and lds_ram
//
// usage
//   request channel (req_*): cmd 0 loads one cylinder request, cmd 1 starts a sweep
//   from req_head in req_direction (0 upward, 1 downward).
//   result channel (rsp_*): one result per stored request with the running seek sum,
//   rsp_last on the final one; a start with nothing stored gives a single result
//   with rsp_empty_res set. rsp_overflow reports loads dropped for lack of room.
// operation
//   requests sit sorted in one ram with a single read and a single write port.
//   a load walks down from the top of the store, one entry at a time (ram read, then
//   compare and write), shifting each larger entry up one slot.
//   a start scans upward from the bottom for the first entry at or above the head,
//   then emits each result through its ram read, distance and output states, using one
//   shared subtract, add and saturate path.
//   a load into a full store only sets the overflow flag.
// reset and stalls
//   reset empties the store and clears the overflow flag; ram contents need no clear.
//   results go through an output register; while rsp_ready is low the sequence waits,
//   and after the last result is registered a new request is accepted.

module look_disk_scheduler_core
   import lds_pkg::*;
#(
   parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
   parameter int CYL_BITS     = CYL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [CYL_PORT_W-1:0] req_cylinder,
   input  logic [CYL_PORT_W-1:0] req_head,
   input  logic                  req_direction,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CYL_PORT_W-1:0] rsp_served_cylinder,
   output logic [SEEK_W-1:0]     rsp_total_seek,
   output logic                  rsp_empty_res,
   output logic                  rsp_overflow,
   output logic                  rsp_last
);

   localparam int AW    = $clog2(MAX_REQUESTS);
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int VW    = CYL_BITS;
   localparam int SUM_W = ((SEEK_W > VW) ? SEEK_W : VW) + 1;
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_REQUESTS);
   localparam logic [SUM_W-1:0] SEEK_LIM = SUM_W'({SEEK_W{1'b1}});

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             up_ff, up_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [VW-1:0]    head_ff, head_in;
   logic             dir_ff, dir_in;
   logic [VW-1:0]    val_ff, val_in;
   logic [VW-1:0]    pos_ff, pos_in;
   logic [VW-1:0]    dist_ff, dist_in;
   logic [VW-1:0]    cyl_ff, cyl_in;
   logic [SEEK_W-1:0] acc_ff, acc_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CYL_PORT_W-1:0] rsp_cyl_ff, rsp_cyl_in;
   logic [SEEK_W-1:0]     rsp_seek_ff, rsp_seek_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [VW-1:0] ram_wdata, ram_rdata;

   logic             accept, out_free, is_last;
   logic [CNT_W-1:0] idx_dec, idx_inc, ptr_inc, k_inc, split;
   logic [SUM_W-1:0] seek_sum;

   lds_ram #(
      .WIDTH(VW),
      .DEPTH(MAX_REQUESTS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign idx_dec  = idx_ff - CNT_W'(1);
   assign idx_inc  = idx_ff + CNT_W'(1);
   assign ptr_inc  = ptr_ff + CNT_W'(1);
   assign k_inc    = k_ff + CNT_W'(1);
   assign is_last  = (k_inc == n_ff);
   assign split    = (ram_rdata < head_ff) ? n_ff : idx_ff;
   assign seek_sum = SUM_W'(acc_ff) + SUM_W'(dist_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_START) begin
                  state_in = (count_ff == '0) ? ST_EMPTY : ST_SP_RD;
               end else if (count_ff != MAX_CNT) begin
                  state_in = (count_ff == '0) ? ST_LD_WR : ST_LD_RD;
               end
            end
         end
         ST_LD_RD:  state_in = ST_LD_CMP;
         ST_LD_CMP: begin
            if (ram_rdata > val_ff) begin
               state_in = (idx_dec == '0) ? ST_LD_WR : ST_LD_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LD_WR: state_in = ST_IDLE;
         ST_EMPTY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SP_RD:  state_in = ST_SP_CMP;
         ST_SP_CMP: begin
            if (ram_rdata < head_ff && idx_inc != n_ff) begin
               state_in = ST_SP_RD;
            end else begin
               state_in = ST_EM_RD;
            end
         end
         ST_EM_RD:  state_in = ST_EM_DIF;
         ST_EM_DIF: state_in = ST_EM_OUT;
         ST_EM_OUT: begin
            if (out_free) begin
               state_in = is_last ? ST_IDLE : ST_EM_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      n_in       = n_ff;
      ovf_in     = ovf_ff;
      idx_in     = idx_ff;
      ptr_in     = ptr_ff;
      up_in      = up_ff;
      k_in       = k_ff;
      head_in    = head_ff;
      dir_in     = dir_ff;
      val_in     = val_ff;
      pos_in     = pos_ff;
      dist_in    = dist_ff;
      cyl_in     = cyl_ff;
      acc_in     = acc_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cyl_in   = rsp_cyl_ff;
      rsp_seek_in  = rsp_seek_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;

      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = val_ff;
      ram_re    = 1'b0;
      ram_raddr = idx_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_START) begin
                  n_in       = count_ff;
                  ovf_in     = dropped_ff;
                  count_in   = '0;
                  dropped_in = 1'b0;
                  head_in    = VW'(req_head);
                  dir_in     = req_direction;
                  idx_in     = '0;
               end else if (count_ff != MAX_CNT) begin
                  idx_in   = count_ff;
                  val_in   = VW'(req_cylinder);
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         ST_LD_RD: begin
            ram_re    = 1'b1;
            ram_raddr = idx_dec[AW-1:0];
         end
         ST_LD_CMP: begin
            // shift the larger entry up one slot, or drop the new value in here
            ram_we = 1'b1;
            if (ram_rdata > val_ff) begin
               ram_wdata = ram_rdata;
               idx_in    = idx_dec;
            end
         end
         ST_LD_WR: begin
            ram_we = 1'b1;
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cyl_in   = '0;
               rsp_seek_in  = '0;
               rsp_empty_in = 1'b1;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = 1'b1;
            end
         end
         ST_SP_RD: begin
            ram_re = 1'b1;
         end
         ST_SP_CMP: begin
            if (ram_rdata < head_ff && idx_inc != n_ff) begin
               idx_in = idx_inc;
            end else begin
               k_in   = '0;
               pos_in = head_ff;
               acc_in = '0;
               // first sweep upward from the split, or downward from just below it
               if (dir_ff == DIR_RIGHT) begin
                  up_in  = (split != n_ff);
                  ptr_in = (split != n_ff) ? split : split - CNT_W'(1);
               end else begin
                  up_in  = (split == '0);
                  ptr_in = (split == '0) ? split : split - CNT_W'(1);
               end
            end
         end
         ST_EM_RD: begin
            ram_re    = 1'b1;
            ram_raddr = ptr_ff[AW-1:0];
         end
         ST_EM_DIF: begin
            cyl_in  = ram_rdata;
            dist_in = (ram_rdata >= pos_ff) ? ram_rdata - pos_ff : pos_ff - ram_rdata;
         end
         ST_EM_OUT: begin
            if (out_free) begin
               acc_in = (seek_sum > SEEK_LIM) ? {SEEK_W{1'b1}} : SEEK_W'(seek_sum);
               rsp_valid_in = 1'b1;
               rsp_cyl_in   = CYL_PORT_W'(cyl_ff);
               rsp_seek_in  = acc_in;
               rsp_empty_in = 1'b0;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = is_last;
               pos_in       = cyl_ff;
               k_in         = k_inc;
               // walk on, turning around at the end of the first sweep
               if (up_ff && ptr_inc != n_ff) begin
                  ptr_in = ptr_inc;
               end else if (up_ff) begin
                  ptr_in = idx_ff - CNT_W'(1);
                  up_in  = 1'b0;
               end else if (ptr_ff != '0) begin
                  ptr_in = ptr_ff - CNT_W'(1);
               end else begin
                  ptr_in = idx_ff;
                  up_in  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      // keep the split point in idx for the turnaround
      if (state_ff == ST_SP_CMP && !(ram_rdata < head_ff && idx_inc != n_ff)) begin
         idx_in = split;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      ovf_ff       <= ovf_in;
      idx_ff       <= idx_in;
      ptr_ff       <= ptr_in;
      up_ff        <= up_in;
      k_ff         <= k_in;
      head_ff      <= head_in;
      dir_ff       <= dir_in;
      val_ff       <= val_in;
      pos_ff       <= pos_in;
      dist_ff      <= dist_in;
      cyl_ff       <= cyl_in;
      acc_ff       <= acc_in;
      rsp_cyl_ff   <= rsp_cyl_in;
      rsp_seek_ff  <= rsp_seek_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_served_cylinder = rsp_cyl_ff;
   assign rsp_total_seek      = rsp_seek_ff;
   assign rsp_empty_res       = rsp_empty_ff;
   assign rsp_overflow        = rsp_ovf_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

>>> rtl/lds_checker.sv
// port level checks for the look disk scheduler, bound to the top level
// depends on lds_pkg and look_disk_scheduler_core

module lds_checker
   import lds_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_cmd,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CYL_PORT_W-1:0] rsp_served_cylinder,
   input logic [SEEK_W-1:0]     rsp_total_seek,
   input logic                  rsp_empty_res,
   input logic                  rsp_last
);

   // a start always leaves the block busy in the cycle after it
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_START |=> !req_ready)
      else $error("request taken right after a start");

   // a load never creates a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("result appeared after a load");

   // the empty-store answer is a single zeroed final result
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |->
         rsp_last && rsp_served_cylinder == '0 && rsp_total_seek == '0)
      else $error("malformed empty result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_served_cylinder) && $stable(rsp_total_seek)
         && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind look_disk_scheduler_core lds_checker u_lds_checker (.*);
